// ----- rtl/lkt_pkg.sv -----
`default_nettype none

package lkt_pkg;

    localparam int KEY_W     = 32;
    localparam int HIT_POS_W = 2;
    localparam int OCC_W     = 3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_key;
        logic update;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_hold;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/lru_key_tracker.sv -----
// ---------------------------------------------------------------------------
//  channel  | handshake            | word
//  ---------+----------------------+---------------------------------------
//  in       | in_valid / in_stall  | key
//  out      | out_valid / out_stall| hit, hit_position, evicted,
//           |                      | evicted_key, occupancy
//
//  Per word: a capture step registers the key, then an update step compares
//  all WAYS positions in parallel and shifts the ordered register file.
//  The result sits in an output register, so the next key is taken while it
//  waits; only a held result stalls the update cycle.
//  rst_n (async, active low) clears the held count and the output valid;
//  key storage is not reset, and only positions below the count are compared.
// ---------------------------------------------------------------------------
`default_nettype none

module lru_key_tracker
#(
    parameter int WAYS = 4
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [lkt_pkg::KEY_W-1:0] key,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 hit,
    output logic [lkt_pkg::HIT_POS_W-1:0]        hit_position,
    output logic                                 evicted,
    output logic signed [lkt_pkg::KEY_W-1:0]     evicted_key,
    output logic [lkt_pkg::OCC_W-1:0]            occupancy
);

    lkt_pkg::ctrl_cmd_t  cmd;
    lkt_pkg::dp_status_t status;

    // sequencing: idle -> capture key -> update and load result
    lkt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // key store, compare, shift, result register
    lkt_dp
    #(
        .WAYS (WAYS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .key          (key),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_position (hit_position),
        .evicted      (evicted),
        .evicted_key  (evicted_key),
        .occupancy    (occupancy)
    );

endmodule

`default_nettype wire

// ----- rtl/lkt_ctrl.sv -----
`default_nettype none

module lkt_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire lkt_pkg::dp_status_t status,
    output lkt_pkg::ctrl_cmd_t      cmd
);

    lkt_pkg::state_t state_reg;
    lkt_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lkt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lkt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lkt_pkg::ST_EXEC;
                end
            end
            lkt_pkg::ST_EXEC:
            begin
                if (!status.out_hold)
                begin
                    state_next = lkt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lkt_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall     = 1'b1;
        cmd.load_key = 1'b0;
        cmd.update   = 1'b0;
        unique case (state_reg)
            lkt_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.load_key = in_valid;
            end
            lkt_pkg::ST_EXEC:
            begin
                cmd.update = !status.out_hold;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lkt_dp.sv -----
`default_nettype none

module lkt_dp
#(
    parameter int WAYS = 4
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic signed [lkt_pkg::KEY_W-1:0] key,
    input  wire lkt_pkg::ctrl_cmd_t              cmd,
    output lkt_pkg::dp_status_t                  status,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic                                 hit,
    output logic [lkt_pkg::HIT_POS_W-1:0]        hit_position,
    output logic                                 evicted,
    output logic signed [lkt_pkg::KEY_W-1:0]     evicted_key,
    output logic [lkt_pkg::OCC_W-1:0]            occupancy
);

    localparam int PW = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CW = $clog2(WAYS + 1);
    localparam logic [CW-1:0] FULL = CW'(WAYS);

    logic [lkt_pkg::KEY_W-1:0] key_reg;
    logic [lkt_pkg::KEY_W-1:0] keys_reg [WAYS];
    logic [lkt_pkg::KEY_W-1:0] keys_next [WAYS];
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      hit_reg;
    logic [lkt_pkg::HIT_POS_W-1:0] hit_pos_reg;
    logic                      evicted_reg;
    logic [lkt_pkg::KEY_W-1:0] ev_key_reg;
    logic [lkt_pkg::OCC_W-1:0] occ_reg;

    logic [WAYS-1:0]           match;
    logic                      found;
    logic [PW-1:0]             pos;
    logic                      full;

    assign full = (count_reg == FULL);

    // parallel compare over occupied positions
    always_comb
    begin
        for (int i = 0; i < WAYS; i++)
        begin
            match[i] = (CW'(i) < count_reg) && (keys_reg[i] == key_reg);
        end
    end

    // lowest matching position wins
    always_comb
    begin
        pos = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                pos = PW'(i);
            end
        end
    end

    assign found = |match;

    // move to front / insert at front
    always_comb
    begin
        keys_next[0] = key_reg;
        for (int i = 1; i < WAYS; i++)
        begin
            if (found && (PW'(i) > pos))
            begin
                keys_next[i] = keys_reg[i];
            end
            else
            begin
                keys_next[i] = keys_reg[i-1];
            end
        end
        count_next = (found || full) ? count_reg : count_reg + CW'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.update)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.update)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= key;
        end
        if (cmd.update)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                keys_reg[i] <= keys_next[i];
            end
            hit_reg     <= found;
            hit_pos_reg <= found ? lkt_pkg::HIT_POS_W'(pos) : '0;
            evicted_reg <= !found && full;
            ev_key_reg  <= (!found && full) ? keys_reg[WAYS-1] : '0;
            occ_reg     <= lkt_pkg::OCC_W'(count_next);
        end
    end

    assign status.out_hold = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign hit             = hit_reg;
    assign hit_position    = hit_pos_reg;
    assign evicted         = evicted_reg;
    assign evicted_key     = ev_key_reg;
    assign occupancy       = occ_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL)
        else $error("held count beyond capacity");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while held");

    a_update_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |=> out_valid_reg)
        else $error("update did not present a result");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && evicted_reg))
        else $error("hit and eviction together");
`endif

endmodule

`default_nettype wire

// ----- sim/lru_key_tracker_test.sv -----
`default_nettype none

module lru_key_tracker_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS      = 4;
    localparam int HALF_CLK  = 6;      // 12 ns period
    localparam int POOL_MAX  = 6;

    // one result word, field by field as the block drives it
    typedef struct packed {
        logic                             hit;
        logic [lkt_pkg::HIT_POS_W-1:0]    hit_position;
        logic                             evicted;
        logic signed [lkt_pkg::KEY_W-1:0] evicted_key;
        logic [lkt_pkg::OCC_W-1:0]        occupancy;
    } access_result_t;

    logic                             clk;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [lkt_pkg::KEY_W-1:0] key;
    logic                             out_valid;
    logic                             out_stall;
    logic                             hit;
    logic [lkt_pkg::HIT_POS_W-1:0]    hit_position;
    logic                             evicted;
    logic signed [lkt_pkg::KEY_W-1:0] evicted_key;
    logic [lkt_pkg::OCC_W-1:0]        occupancy;

    // predicted contents of the tracker: most recent first
    logic [lkt_pkg::KEY_W-1:0]        lru_keys [WAYS];
    int                               held;

    access_result_t                   expected_results [$];
    int                               mismatches;

    // idling: per-word waits are drawn from 0 .. *_max
    int                               tx_max;
    int                               rx_max;
    int                               rx_wait;
    int                               hold_off;     // long receiver hold, in cycles

    // key pool for the random part, so that hits and evictions are frequent
    logic [lkt_pkg::KEY_W-1:0]        key_pool [POOL_MAX];
    int                               pool_size;

    lru_key_tracker
    #(
        .WAYS (WAYS)
    )
    dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .key          (key),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .hit          (hit),
        .hit_position (hit_position),
        .evicted      (evicted),
        .evicted_key  (evicted_key),
        .occupancy    (occupancy)
    );

    always
    begin
        clk = 1'b1;
        #HALF_CLK;
        clk = 1'b0;
        #HALF_CLK;
    end

    // -----------------------------------------------------------------------
    //  Predictor: one access to the tracker.
    //  Hit  - key moves to the front, the keys ahead of it shift down one.
    //  Miss - key goes in at the front; a full store drops its last key.
    // -----------------------------------------------------------------------
    function automatic access_result_t lru_access(input logic [lkt_pkg::KEY_W-1:0] k);
        access_result_t r;
        int             pos;
        int             i;
        bit             found;

        r     = '0;
        pos   = 0;
        found = 1'b0;
        for (i = 0; i < held; i++)
        begin
            if (!found && lru_keys[i] == k)
            begin
                found = 1'b1;
                pos   = i;
            end
        end

        if (found)
        begin
            r.hit          = 1'b1;
            r.hit_position = lkt_pkg::HIT_POS_W'(pos);
            for (i = pos; i > 0; i--)
                lru_keys[i] = lru_keys[i-1];
        end
        else if (held == WAYS)
        begin
            r.evicted     = 1'b1;
            r.evicted_key = lru_keys[WAYS-1];
            for (i = WAYS - 1; i > 0; i--)
                lru_keys[i] = lru_keys[i-1];
        end
        else
        begin
            for (i = held; i > 0; i--)
                lru_keys[i] = lru_keys[i-1];
            held++;
        end
        lru_keys[0] = k;
        r.occupancy = lkt_pkg::OCC_W'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // -----------------------------------------------------------------------
    //  Result checker. Sampled at the rising edge, so the values seen are
    //  those that stood over the edge. Each accepted word also draws the
    //  receiver's wait before the next one.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        access_result_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            rx_wait = $urandom_range(0, rx_max);
            if (expected_results.size() == 0)
            begin
                report_mismatch("result word with nothing outstanding");
            end
            else
            begin
                want = expected_results.pop_front();
                if (hit !== want.hit)
                    report_mismatch($sformatf("hit %0b, want %0b", hit, want.hit));
                if (hit_position !== want.hit_position)
                    report_mismatch($sformatf("hit_position %0d, want %0d",
                                              hit_position, want.hit_position));
                if (evicted !== want.evicted)
                    report_mismatch($sformatf("evicted %0b, want %0b",
                                              evicted, want.evicted));
                if (evicted_key !== want.evicted_key)
                    report_mismatch($sformatf("evicted_key %h, want %h",
                                              evicted_key, want.evicted_key));
                if (occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, want %0d",
                                              occupancy, want.occupancy));
            end
        end
    end

    // Receiver stall: a long hold-off wins over the per-word wait.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_stall <= 1'b1;
                hold_off--;
            end
            else if (rx_wait > 0)
            begin
                out_stall <= 1'b1;
                rx_wait--;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    //  Sender: called at a falling edge, returns at a falling edge.
    //  With no gap, in_valid stays high and only the key changes.
    // -----------------------------------------------------------------------
    task automatic send_key(input logic [lkt_pkg::KEY_W-1:0] k);
        int gap;

        gap = $urandom_range(0, tx_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        key      <= k;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(lru_access(k));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // new pool of 2 .. POOL_MAX keys; some extremes mixed in
    task automatic refill_pool();
        int i;

        pool_size = $urandom_range(2, POOL_MAX);
        for (i = 0; i < pool_size; i++)
        begin
            case ($urandom_range(0, 7))
                0:       key_pool[i] = 32'h8000_0000;
                1:       key_pool[i] = 32'h7FFF_FFFF;
                2:       key_pool[i] = 32'hFFFF_FFFF;
                3:       key_pool[i] = 32'h0000_0000;
                default: key_pool[i] = $urandom;
            endcase
        end
    endtask

    // mostly pool keys, a fifth fully random (nearly always a miss)
    task automatic send_random(input int count);
        int n;

        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 4) == 0)
                send_key($urandom);
            else
                send_key(key_pool[$urandom_range(0, pool_size - 1)]);
        end
    endtask

    // -----------------------------------------------------------------------
    //  Tests
    // -----------------------------------------------------------------------

    // Fill from empty with the extreme keys, hit every position (the front
    // one included, which leaves the order alone), then evict four times.
    task automatic test_fill_hit_evict();
        send_key(32'h0000_0000);      // first key into an empty store
        send_key(32'hFFFF_FFFF);
        send_key(32'h8000_0000);
        send_key(32'h7FFF_FFFF);      // now full
        send_key(32'h7FFF_FFFF);      // front hit
        send_key(32'h0000_0000);      // hit at the back
        send_key(32'h7FFF_FFFF);
        send_key(32'h8000_0000);
        send_key(32'h5555_5555);      // miss on a full store: evicts
        send_key(32'hAAAA_AAAA);
        send_key(32'h5555_5555);
        send_key(32'h8000_0000);
        send_key(32'h1234_5678);
        send_key(32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Receiver holds off for a long stretch while keys keep coming, so the
    // tracker fills its output register and stalls its input. Then the
    // sender pauses until every word has come back.
    task automatic test_output_backpressure();
        refill_pool();
        hold_off = 80;
        send_random(30);
        wait_drained();
    endtask

    // Back-to-back on both sides: no idling at all.
    task automatic test_full_rate();
        tx_max = 0;
        rx_max = 0;
        refill_pool();
        send_random(75);
        refill_pool();
        send_random(75);
        wait_drained();
        tx_max = 15;
        rx_max = 15;
    endtask

    // Random keys in chunks, each with a fresh pool and its own idling mix.
    task automatic test_random_keys(input int chunks);
        int c;

        for (c = 0; c < chunks; c++)
        begin
            refill_pool();
            case ($urandom_range(0, 3))
                0:       begin tx_max = 0;  rx_max = 15; end
                1:       begin tx_max = 15; rx_max = 0;  end
                2:       begin tx_max = 3;  rx_max = 3;  end
                default: begin tx_max = 15; rx_max = 15; end
            endcase
            send_random(40);
        end
        tx_max = 15;
        rx_max = 15;
        wait_drained();
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        key        = '0;
        held       = 0;
        mismatches = 0;
        tx_max     = 15;
        rx_max     = 15;
        rx_wait    = 0;
        hold_off   = 0;
        pool_size  = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_fill_hit_evict();
        test_output_backpressure();
        test_full_rate();
        test_random_keys(13);
        test_output_backpressure();

        // settle before the verdict
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("lru_key_tracker_test passed");
        else
            $display("lru_key_tracker_test failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("lru_key_tracker_test failed");
        $finish;
    end

endmodule

`default_nettype wire
